>>> src/mck_pkg.sv
package mck_pkg;

    // Longest Morse code handled; no table entry reaches past it
    localparam int MaxElements = 6;
    localparam int ErrorBlinks = 5;
    localparam int NumCodes    = 43;

    localparam int LenW  = $clog2(MaxElements + 1);
    localparam int TimeW = 12;

    // Configuration register indexes
    localparam logic [2:0] CFG_LAMP_LEVEL     = 3'd0;
    localparam logic [2:0] CFG_DOT_TIME       = 3'd1;
    localparam logic [2:0] CFG_DASH_TIME      = 3'd2;
    localparam logic [2:0] CFG_ELEMENT_GAP    = 3'd3;
    localparam logic [2:0] CFG_CHAR_GAP       = 3'd4;
    localparam logic [2:0] CFG_LINE_PAUSE     = 3'd5;
    localparam logic [2:0] CFG_ERROR_ON_TIME  = 3'd6;
    localparam logic [2:0] CFG_ERROR_OFF_TIME = 3'd7;

    typedef enum logic [1:0] {
        KIND_SPACE,
        KIND_LINE,
        KIND_ERROR,
        KIND_MORSE
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [LenW-1:0]        len;
        logic [MaxElements-1:0] bits;
    } char_info_t;

    // Element count and pattern (first element in highest used bit, 1 = dash).
    // Order: A-Z, 0-9, then , . ; : ' " -
    localparam logic [LenW-1:0] CODE_LEN [NumCodes] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6
    };

    localparam logic [MaxElements-1:0] CODE_BITS [NumCodes] = '{
        6'd1,  6'd8,  6'd10, 6'd4,  6'd0,  6'd2,  6'd6,  6'd0,  6'd0,  6'd7,
        6'd5,  6'd4,  6'd3,  6'd2,  6'd7,  6'd6,  6'd13, 6'd2,  6'd0,  6'd1,
        6'd1,  6'd1,  6'd3,  6'd9,  6'd11, 6'd12,
        6'd31, 6'd15, 6'd7,  6'd3,  6'd1,  6'd0,  6'd16, 6'd24, 6'd28, 6'd30,
        6'd51, 6'd21, 6'd42, 6'd56, 6'd30, 6'd18, 6'd33
    };

    // Classify one byte and fetch its Morse pattern
    function automatic char_info_t decode_char(input logic [7:0] c);
        char_info_t  info;
        logic [7:0]  diff;
        logic [5:0]  idx;
        logic        found;
        info  = '{kind: KIND_ERROR, len: LenW'(ErrorBlinks), bits: '0};
        diff  = 8'd0;
        idx   = 6'd0;
        found = 1'b0;
        if (c >= 8'h61 && c <= 8'h7a) begin
            diff  = c - 8'h61;
            idx   = diff[5:0];
            found = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            diff  = c - 8'h41;
            idx   = diff[5:0];
            found = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            diff  = c - 8'h30 + 8'd26;
            idx   = diff[5:0];
            found = 1'b1;
        end else begin
            found = 1'b1;
            case (c)
                8'h2c:   idx = 6'd36;
                8'h2e:   idx = 6'd37;
                8'h3b:   idx = 6'd38;
                8'h3a:   idx = 6'd39;
                8'h27:   idx = 6'd40;
                8'h22:   idx = 6'd41;
                8'h2d:   idx = 6'd42;
                default: found = 1'b0;
            endcase
        end
        if (c == 8'h20) begin
            info = '{kind: KIND_SPACE, len: LenW'(1), bits: '0};
        end else if (c == 8'h0a || c == 8'h0d) begin
            info = '{kind: KIND_LINE, len: LenW'(1), bits: '0};
        end else if (found) begin
            info = '{kind: KIND_MORSE, len: CODE_LEN[idx], bits: CODE_BITS[idx]};
        end
        return info;
    endfunction

endpackage

>>> src/morse_character_keyer.sv
// A character beat is taken into the character register, and its pulse beats are registered
// in the output register, one pulse beat per cycle while out_stall does not hold them; a
// character holds the input while its pulses go out (1 for a pause, 1 to 6 for Morse,
// 5 for an error), set by the pulse counter in the character register. The next character
// is taken with the last pulse. Reset (rst_n, asynchronous, active low) empties the block
// and loads the default configuration values.
module morse_character_keyer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [2:0]                cfg_index,
    input  logic [mck_pkg::TimeW-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                char_code,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      lamp_select,
    output logic [7:0]                drive_level,
    output logic                      tone_enable,
    output logic [mck_pkg::TimeW-1:0] on_time,
    output logic [mck_pkg::TimeW:0]   off_time,
    output logic                      bad_char,
    output logic                      last_pulse
);
    import mck_pkg::*;

    // Configuration registers
    logic [7:0]       lamp_level_reg;
    logic [TimeW-1:0] dot_time_reg;
    logic [TimeW-1:0] dash_time_reg;
    logic [TimeW-1:0] element_gap_reg;
    logic [TimeW-1:0] char_gap_reg;
    logic [TimeW-1:0] line_pause_reg;
    logic [TimeW-1:0] error_on_time_reg;
    logic [TimeW-1:0] error_off_time_reg;

    // Character register and pulse counter
    logic            item_valid_reg, item_valid_next;
    char_info_t      item_reg, item_next;
    logic [LenW-1:0] count_reg, count_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic            lamp_select_reg, lamp_select_next;
    logic [7:0]      drive_level_reg, drive_level_next;
    logic            tone_enable_reg, tone_enable_next;
    logic [TimeW-1:0] on_time_reg, on_time_next;
    logic [TimeW:0]  off_time_reg, off_time_next;
    logic            bad_char_reg, bad_char_next;
    logic            last_pulse_reg, last_pulse_next;

    logic            load_out;
    logic            is_last;
    logic            item_done;
    logic            accept;
    logic [LenW-1:0] elem_pos;
    logic            is_dash;
    logic [TimeW:0]  extra_gap;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_level_reg     <= 8'd100;
            dot_time_reg       <= 12'd300;
            dash_time_reg      <= 12'd1000;
            element_gap_reg    <= 12'd200;
            char_gap_reg       <= 12'd750;
            line_pause_reg     <= 12'd2000;
            error_on_time_reg  <= 12'd100;
            error_off_time_reg <= 12'd25;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LAMP_LEVEL:     lamp_level_reg     <= cfg_data[7:0];
                CFG_DOT_TIME:       dot_time_reg       <= cfg_data;
                CFG_DASH_TIME:      dash_time_reg      <= cfg_data;
                CFG_ELEMENT_GAP:    element_gap_reg    <= cfg_data;
                CFG_CHAR_GAP:       char_gap_reg       <= cfg_data;
                CFG_LINE_PAUSE:     line_pause_reg     <= cfg_data;
                CFG_ERROR_ON_TIME:  error_on_time_reg  <= cfg_data;
                CFG_ERROR_OFF_TIME: error_off_time_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Handshake control
    assign load_out  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign is_last   = (count_reg == item_reg.len - LenW'(1));
    assign item_done = load_out && is_last;
    assign in_stall  = item_valid_reg && !item_done;
    assign accept    = in_valid && !in_stall;

    // Character register update
    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            item_next       = decode_char(char_code);
            count_next      = '0;
        end
        else if (item_done)
        begin
            item_valid_next = 1'b0;
        end
        else if (load_out)
        begin
            count_next = count_reg + LenW'(1);
        end
    end

    // Pulse fields for the current element
    assign elem_pos  = item_reg.len - LenW'(1) - count_reg;
    assign is_dash   = item_reg.bits[elem_pos];
    assign extra_gap = is_last ? {1'b0, char_gap_reg} : '0;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        lamp_select_next = lamp_select_reg;
        drive_level_next = drive_level_reg;
        tone_enable_next = tone_enable_reg;
        on_time_next     = on_time_reg;
        off_time_next    = off_time_reg;
        bad_char_next    = bad_char_reg;
        last_pulse_next  = last_pulse_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            last_pulse_next = is_last;
            unique case (item_reg.kind)
                KIND_SPACE:
                begin
                    lamp_select_next = 1'b0;
                    drive_level_next = 8'd0;
                    tone_enable_next = 1'b0;
                    on_time_next     = '0;
                    off_time_next    = {1'b0, char_gap_reg};
                    bad_char_next    = 1'b0;
                end
                KIND_LINE:
                begin
                    lamp_select_next = 1'b0;
                    drive_level_next = 8'd0;
                    tone_enable_next = 1'b0;
                    on_time_next     = '0;
                    off_time_next    = {1'b0, line_pause_reg};
                    bad_char_next    = 1'b0;
                end
                KIND_ERROR:
                begin
                    lamp_select_next = 1'b1;
                    drive_level_next = lamp_level_reg;
                    tone_enable_next = 1'b0;
                    on_time_next     = error_on_time_reg;
                    off_time_next    = {1'b0, error_off_time_reg} + extra_gap;
                    bad_char_next    = 1'b1;
                end
                KIND_MORSE:
                begin
                    lamp_select_next = 1'b0;
                    drive_level_next = lamp_level_reg;
                    tone_enable_next = 1'b1;
                    on_time_next     = is_dash ? dash_time_reg : dot_time_reg;
                    off_time_next    = {1'b0, element_gap_reg} + extra_gap;
                    bad_char_next    = 1'b0;
                end
                default:
                begin
                    lamp_select_next = 1'b0;
                end
            endcase
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        count_reg       <= count_next;
        lamp_select_reg <= lamp_select_next;
        drive_level_reg <= drive_level_next;
        tone_enable_reg <= tone_enable_next;
        on_time_reg     <= on_time_next;
        off_time_reg    <= off_time_next;
        bad_char_reg    <= bad_char_next;
        last_pulse_reg  <= last_pulse_next;
    end

    assign out_valid   = out_valid_reg;
    assign lamp_select = lamp_select_reg;
    assign drive_level = drive_level_reg;
    assign tone_enable = tone_enable_reg;
    assign on_time     = on_time_reg;
    assign off_time    = off_time_reg;
    assign bad_char    = bad_char_reg;
    assign last_pulse  = last_pulse_reg;

endmodule
